>>> rtl/core/sac_pkg.sv
// Shared types and constants for the set-associative cache core.
package sac_pkg;
    localparam int WAYS = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } ctrl_t;

    function automatic logic [6:0] tree_touch(input logic [6:0] t, input logic [2:0] w);
        logic [6:0] r;
        r = t;
        r[0] = ~w[2];
        if (!w[2])
        begin
            r[1] = ~w[1];
            if (w[1]) r[3] = ~w[0]; else r[2] = ~w[0];
        end
        else
        begin
            r[4] = ~w[1];
            if (w[1]) r[6] = ~w[0]; else r[5] = ~w[0];
        end
        return r;
    endfunction

    function automatic logic [2:0] tree_victim(input logic [6:0] t);
        logic m;
        logic l;
        if (!t[0])
        begin
            m = t[1];
            l = m ? t[3] : t[2];
        end
        else
        begin
            m = t[4];
            l = m ? t[6] : t[5];
        end
        return {t[0], m, l};
    endfunction
endpackage

>>> rtl/core/sac_if.sv
// Valid/ready channel interface carrying a payload item.
interface sac_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/set_assoc_cache_tree_plru_core.sv
// Eight-way set-associative cache with tree PLRU: each access steps through accept with
// tag RAM read, compare, update and result, using the single-port tag RAM per way,
// which is read for each access and written on a miss. A result waits in the
// output register until taken; the next access is accepted after that.
module set_assoc_cache_tree_plru_core #(
    parameter int LINE_BYTES = 64,
    parameter int NUM_SETS   = 64,
    parameter int ADDR_BITS  = 48
) (
    input logic clk,
    input logic rst_n,
    sac_if.sink   req,
    sac_if.source rsp
);
    import sac_pkg::*;
    ctrl_t ctrl;

    sac_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .ctrl(ctrl));

    sac_dp #(.LINE_BYTES(LINE_BYTES), .NUM_SETS(NUM_SETS), .ADDR_BITS(ADDR_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
        .address(req.data.address), .is_write(req.data.is_write),
        .hit(rsp.data.hit), .way_used(rsp.data.way_used),
        .victim_valid(rsp.data.victim_valid), .victim_address(rsp.data.victim_address),
        .writeback(rsp.data.writeback), .hit_total(rsp.data.hit_total),
        .miss_total(rsp.data.miss_total), .writeback_total(rsp.data.writeback_total));
endmodule

>>> rtl/core/sac_ram.sv
// Generic single-port RAM with registered read.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/sac_ctrl.sv
// Controller state machine sequencing read, update and result delivery.
module sac_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output sac_pkg::ctrl_t ctrl
);
    import sac_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.load = in_valid;
                if (in_valid) state_next = ST_READ;
            end
            ST_READ:
            begin
                ctrl.compare = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctrl.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/core/sac_dp.sv
// Datapath: tag RAMs, per-set state flops, compare, replacement and counters.
module sac_dp #(
    parameter int LINE_BYTES = 64,
    parameter int NUM_SETS   = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sac_pkg::ctrl_t ctrl,
    input  logic [47:0]    address,
    input  logic           is_write,
    output logic           hit,
    output logic [2:0]     way_used,
    output logic           victim_valid,
    output logic [47:0]    victim_address,
    output logic           writeback,
    output logic [31:0]    hit_total,
    output logic [31:0]    miss_total,
    output logic [31:0]    writeback_total
);
    import sac_pkg::*;
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int AW = (ADDR_BITS < 48) ? ADDR_BITS : 48;

    logic [47:0] addr_reg;
    logic wr_reg;
    logic [SET_BITS-1:0] set_idx;
    logic [SET_BITS-1:0] in_set;
    logic [SET_BITS-1:0] ram_addr;
    logic [47:0] rdata [WAYS];
    logic [WAYS-1:0] we;
    logic [7:0] valid_reg [NUM_SETS];
    logic [7:0] dirty_reg [NUM_SETS];
    logic [6:0] tree_reg [NUM_SETS];
    logic [7:0] vm_reg, dm_reg;
    logic [6:0] tb_reg;
    logic [7:0] match_reg;
    logic [31:0] hc_reg, mc_reg, wc_reg;
    logic [47:0] addr_m;

    assign addr_m = (AW == 48) ? address : (address & ((48'd1 << AW) - 48'd1));
    // Set index of the held item (set count is a power of two)
    assign set_idx = (NUM_SETS > 1) ? SET_BITS'(addr_reg >> OFF_BITS) : '0;
    assign in_set = (NUM_SETS > 1) ? SET_BITS'(addr_m >> OFF_BITS) : '0;
    // Tag RAMs are read with the incoming set while the item is taken
    assign ram_addr = ctrl.load ? in_set : set_idx;

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        sac_ram #(.WIDTH(48), .DEPTH(NUM_SETS)) u_ram (
            .clk(clk), .we(we[g]), .addr(ram_addr), .wdata(addr_reg), .rdata(rdata[g]));
    end

    // Hit and replacement decisions from the stored compare results
    logic hit_c;
    logic [2:0] hw_c, inv_c, fill_c;
    logic inv_f;
    always_comb
    begin
        hit_c = 1'b0; hw_c = '0; inv_f = 1'b0; inv_c = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match_reg[i]) begin hit_c = 1'b1; hw_c = 3'(i); end
            if (!vm_reg[i]) begin inv_f = 1'b1; inv_c = 3'(i); end
        end
        fill_c = inv_f ? inv_c : tree_victim(tb_reg);
        for (int i = 0; i < WAYS; i++)
            we[i] = ctrl.commit && !hit_c && (fill_c == 3'(i));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin addr_reg <= addr_m; wr_reg <= is_write; end
        if (ctrl.compare)
        begin
            vm_reg <= valid_reg[set_idx];
            dm_reg <= dirty_reg[set_idx];
            tb_reg <= tree_reg[set_idx];
            for (int i = 0; i < WAYS; i++)
                match_reg[i] <= valid_reg[set_idx][i] &&
                    ((rdata[i] >> OFF_BITS) == (addr_reg >> OFF_BITS));
        end
        if (ctrl.commit)
        begin
            hit <= hit_c;
            way_used <= hit_c ? hw_c : fill_c;
            victim_valid <= !hit_c && !inv_f;
            victim_address <= (!hit_c && !inv_f) ? rdata[fill_c] : '0;
            writeback <= !hit_c && !inv_f && dm_reg[fill_c];
        end
    end

    // Per-set state flops and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0; dirty_reg[s] <= '0; tree_reg[s] <= '0;
            end
            hc_reg <= '0; mc_reg <= '0; wc_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            tree_reg[set_idx] <= tree_touch(tb_reg, hit_c ? hw_c : fill_c);
            if (hit_c)
            begin
                if (wr_reg) dirty_reg[set_idx][hw_c] <= 1'b1;
                hc_reg <= hc_reg + 32'd1;
            end
            else
            begin
                valid_reg[set_idx][fill_c] <= 1'b1;
                dirty_reg[set_idx][fill_c] <= wr_reg;
                mc_reg <= mc_reg + 32'd1;
                if (!inv_f && dm_reg[fill_c]) wc_reg <= wc_reg + 32'd1;
            end
        end
    end

    assign hit_total = hc_reg;
    assign miss_total = mc_reg;
    assign writeback_total = wc_reg;
endmodule

>>> rtl/core/sac_checker.sv
// Port-level checker for the cache core, bound to the top level.
module sac_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit,
    input logic victim_valid,
    input logic writeback
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !victim_valid && !writeback) else $error("victim on hit");
    a_wb_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && writeback |-> victim_valid) else $error("writeback without victim");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##3 out_valid) else $error("result late");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
endmodule

bind set_assoc_cache_tree_plru_core sac_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .hit(rsp.data.hit),
    .victim_valid(rsp.data.victim_valid), .writeback(rsp.data.writeback));

>>> tb/set_assoc_cache_tree_plru_core_test.sv
// Testbench for the eight-way tree-PLRU cache core: directed and random accesses.
`timescale 1ns / 100ps

module set_assoc_cache_tree_plru_core_test;
    import sac_pkg::*;

    localparam int LINE_BYTES = 64;
    localparam int NUM_SETS   = 64;
    localparam int ADDR_BITS  = 48;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [47:0] address;
        logic        is_write;
    } access_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way_used;
        logic        victim_valid;
        logic [47:0] victim_address;
        logic        writeback;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] writeback_total;
    } outcome_t;

    logic clk;
    logic rst_n;

    sac_if #(.T(access_t))  req_ch ();
    sac_if #(.T(outcome_t)) rsp_ch ();

    set_assoc_cache_tree_plru_core #(
        .LINE_BYTES(LINE_BYTES),
        .NUM_SETS(NUM_SETS),
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Shadow copy of the cache contents
    logic [47:0] shadow_line [NUM_SETS][WAYS];
    logic [7:0]  shadow_valid [NUM_SETS];
    logic [7:0]  shadow_dirty [NUM_SETS];
    logic [6:0]  shadow_tree [NUM_SETS];
    logic [31:0] hits_seen;
    logic [31:0] misses_seen;
    logic [31:0] writebacks_seen;

    outcome_t    pending_outcomes [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          ready_pct;
    logic [41:0] tag_pool [16];
    logic [5:0]  set_pool [4];

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Point the tree bits on the path away from the way just used
    function automatic logic [6:0] plru_mark(input logic [6:0] t, input logic [2:0] w);
        logic [6:0] n;
        n = t;
        n[0] = !w[2];
        case (w[2:1])
            2'b00: begin n[1] = 1'b1; n[2] = !w[0]; end
            2'b01: begin n[1] = 1'b0; n[3] = !w[0]; end
            2'b10: begin n[4] = 1'b1; n[5] = !w[0]; end
            default: begin n[4] = 1'b0; n[6] = !w[0]; end
        endcase
        return n;
    endfunction

    // Follow the tree bits to the way to replace
    function automatic logic [2:0] plru_pick(input logic [6:0] t);
        logic [2:0] w;
        w[2] = t[0];
        w[1] = t[0] ? t[4] : t[1];
        case ({w[2], w[1]})
            2'b00: w[0] = t[2];
            2'b01: w[0] = t[3];
            2'b10: w[0] = t[5];
            default: w[0] = t[6];
        endcase
        return w;
    endfunction

    // Apply one access to the shadow cache and return its outcome
    function automatic outcome_t cache_lookup(input access_t a);
        outcome_t   o;
        logic [41:0] line;
        logic [5:0]  set;
        logic [2:0]  way;
        logic        found;
        o = '0;
        line = a.address[47:6];
        set = a.address[11:6];
        found = 1'b0;
        way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (shadow_valid[set][i] && shadow_line[set][i][47:6] == line)
            begin
                found = 1'b1;
                way = 3'(i);
            end
        end
        if (found)
        begin
            shadow_tree[set] = plru_mark(shadow_tree[set], way);
            if (a.is_write)
                shadow_dirty[set][way] = 1'b1;
            hits_seen++;
            o.hit = 1'b1;
        end
        else
        begin
            if (shadow_valid[set] != 8'hFF)
            begin
                for (int i = WAYS - 1; i >= 0; i--)
                    if (!shadow_valid[set][i])
                        way = 3'(i);
            end
            else
            begin
                way = plru_pick(shadow_tree[set]);
                o.victim_valid = 1'b1;
                o.victim_address = shadow_line[set][way];
                o.writeback = shadow_dirty[set][way];
            end
            shadow_tree[set] = plru_mark(shadow_tree[set], way);
            shadow_line[set][way] = a.address;
            shadow_valid[set][way] = 1'b1;
            shadow_dirty[set][way] = a.is_write;
            misses_seen++;
            if (o.writeback)
                writebacks_seen++;
        end
        o.way_used = way;
        o.hit_total = hits_seen;
        o.miss_total = misses_seen;
        o.writeback_total = writebacks_seen;
        return o;
    endfunction

    // Send one access; valid stays high while a burst lasts
    task automatic send_access(input logic [47:0] addr, input logic wr);
        access_t a;
        int      gap;
        a.address = addr;
        a.is_write = wr;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 16);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= a;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_outcomes.push_back(cache_lookup(a));
        burst_left--;
    endtask

    // Stop sending and wait until every outcome has been checked
    task automatic drain;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Outcome checker
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: outcome with none expected: %h", $time, rsp_ch.data);
                error_count++;
            end
            else
            begin
                outcome_t e;
                outcome_t g;
                e = pending_outcomes.pop_front();
                g = rsp_ch.data;
                if (g.hit !== e.hit)
                    $display("%0t: hit exp %0d got %0d", $time, e.hit, g.hit);
                if (g.way_used !== e.way_used)
                    $display("%0t: way_used exp %0d got %0d", $time, e.way_used, g.way_used);
                if (g.victim_valid !== e.victim_valid)
                    $display("%0t: victim_valid exp %0d got %0d", $time,
                             e.victim_valid, g.victim_valid);
                if (g.victim_address !== e.victim_address)
                    $display("%0t: victim_address exp %h got %h", $time,
                             e.victim_address, g.victim_address);
                if (g.writeback !== e.writeback)
                    $display("%0t: writeback exp %0d got %0d", $time, e.writeback, g.writeback);
                if (g.hit_total !== e.hit_total)
                    $display("%0t: hit_total exp %0d got %0d", $time, e.hit_total, g.hit_total);
                if (g.miss_total !== e.miss_total)
                    $display("%0t: miss_total exp %0d got %0d", $time,
                             e.miss_total, g.miss_total);
                if (g.writeback_total !== e.writeback_total)
                    $display("%0t: writeback_total exp %0d got %0d", $time,
                             e.writeback_total, g.writeback_total);
                if (g !== e)
                    error_count++;
            end
        end
    end

    // Address extremes and line-offset aliasing
    task automatic test_extremes;
        send_access(48'h0, 1'b0);
        send_access(48'hFFFF_FFFF_FFFF, 1'b1);
        send_access(48'h0000_0000_003F, 1'b1);
        send_access(48'hFFFF_FFFF_FFC0, 1'b0);
        send_access(48'hAAAA_AAAA_AAAA, 1'b0);
        send_access(48'h5555_5555_5555, 1'b1);
        drain();
    endtask

    // Fill one set, hit in it, then evict clean and dirty lines
    task automatic test_fill_and_evict;
        for (int i = 0; i < 8; i++)
            send_access({28'(i * 3 + 1), 8'h00, 6'd5, 6'(i)}, 1'(i % 2));
        send_access({28'd4, 8'h00, 6'd5, 6'd9}, 1'b1);
        send_access({28'd7, 8'h00, 6'd5, 6'd0}, 1'b0);
        for (int i = 0; i < 6; i++)
            send_access({28'(100 + i), 8'h00, 6'd5, 6'(i)}, 1'b0);
        drain();
    endtask

    // Random traffic over a few sets and a small tag pool
    task automatic test_random_traffic(input int count, input int pct);
        logic [47:0] addr;
        ready_pct = pct;
        for (int i = 0; i < 16; i++)
            tag_pool[i] = 42'({$urandom(), $urandom()});
        for (int i = 0; i < 4; i++)
            set_pool[i] = 6'($urandom());
        set_pool[0] = 6'd0;
        set_pool[1] = 6'd63;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                addr = 48'({$urandom(), $urandom()});
            else
                addr = {tag_pool[$urandom_range(0, 11)], set_pool[$urandom_range(0, 3)],
                        6'($urandom())};
            send_access(addr, 1'($urandom()));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        burst_left = 0;
        ready_pct = 100;
        hits_seen = '0;
        misses_seen = '0;
        writebacks_seen = '0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            shadow_valid[s] = '0;
            shadow_dirty[s] = '0;
            shadow_tree[s] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        ready_pct = 60;
        test_fill_and_evict();
        test_random_traffic(200, 100);
        test_random_traffic(200, 50);
        test_random_traffic(200, 85);
        test_random_traffic(200, 20);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> set_assoc_cache_tree_plru_core.f
rtl/core/sac_pkg.sv
rtl/core/sac_if.sv
rtl/core/sac_ram.sv
rtl/core/sac_ctrl.sv
rtl/core/sac_dp.sv
rtl/core/set_assoc_cache_tree_plru_core.sv
rtl/core/sac_checker.sv
tb/set_assoc_cache_tree_plru_core_test.sv
